// File: hw/rtl/scps_pkg.sv
// Shared types and constants for the servo CAN poll sequencer.
package scps_pkg;

  localparam logic [10:0] TX_BASE  = 11'h640;
  localparam logic [10:0] RX_BASE  = 11'h5C0;
  localparam logic [7:0]  ACK_BYTE = 8'h3E;

  // Held mode after reset; writes to the none-mode register index are not stored.
  localparam logic [7:0]  NONE_MODE_RESET = 8'd0;

  // Configuration register indexes
  localparam logic [2:0] CFG_NODE_ID       = 3'd0;
  localparam logic [2:0] CFG_ACCEPT_SETPTS = 3'd1;
  localparam logic [2:0] CFG_NONE_MODE     = 3'd2;
  localparam logic [2:0] CFG_TORQUE_MODE   = 3'd3;
  localparam logic [2:0] CFG_SPEED_MODE    = 3'd4;
  localparam logic [2:0] CFG_POSITION_MODE = 3'd5;

  // Sequencer state codes
  localparam logic [3:0] ST_OFF       = 4'd0;
  localparam logic [3:0] ST_SEND_EN   = 4'd1;
  localparam logic [3:0] ST_SEND_MODE = 4'd2;
  localparam logic [3:0] ST_SEND_TGT  = 4'd3;
  localparam logic [3:0] ST_WAIT_ACK  = 4'd4;
  localparam logic [3:0] ST_SPD_REQ   = 4'd5;
  localparam logic [3:0] ST_SPD_RSP   = 4'd6;
  localparam logic [3:0] ST_POS_REQ   = 4'd7;
  localparam logic [3:0] ST_POS_RSP   = 4'd8;
  localparam logic [3:0] ST_CUR_REQ   = 4'd9;
  localparam logic [3:0] ST_CUR_RSP   = 4'd10;
  localparam logic [3:0] ST_TRQ_REQ   = 4'd11;
  localparam logic [3:0] ST_TRQ_RSP   = 4'd12;
  localparam logic [3:0] ST_ERROR     = 4'd13;

  // Fixed poll request payloads, byte 0 in the low bits
  localparam logic [47:0] REQ_SPEED   = 48'h0000_0100_0500;
  localparam logic [47:0] REQ_POS     = 48'h0000_0000_0200;
  localparam logic [47:0] REQ_CURRENT = 48'h0000_0000_0800;
  localparam logic [47:0] REQ_TORQUE  = 48'h0000_0000_1901;

  typedef struct packed {
    logic [3:0]        seq;
    logic [3:0]        after_ack;
    logic              held_enable;
    logic [7:0]        held_mode;
    logic [31:0]       held_target;
    logic              sent_enable;
    logic [7:0]        sent_mode;
    logic              frame_pending;
    logic [3:0]        pending_len;
    logic [63:0]       pending_bytes;
    logic [3:0][31:0]  readings;
    logic [3:0][15:0]  fails;
  } ctx_t;

  typedef struct packed {
    logic        cmd;
    logic        run;
    logic        enable_request;
    logic [7:0]  mode_request;
    logic [31:0] target_value;
    logic [10:0] rx_id;
    logic [3:0]  rx_len;
    logic [63:0] rx_bytes;
  } item_t;

  typedef struct packed {
    logic [6:0] node_id;
    logic       accept_setpoints;
    logic [7:0] torque_mode_code;
    logic [7:0] speed_mode_code;
  } cfg_t;

  typedef struct packed {
    logic        valid;
    logic [10:0] id;
    logic [2:0]  len;
    logic [47:0] bytes;
  } tx_t;

endpackage

// File: hw/rtl/servo_can_poll_sequencer_top.sv
// Top level of the servo CAN poll sequencer.
//
//  port group | dir | handshake          | content
//  in_*       | in  | in_valid/in_stall   | tick or received frame word
//  out_*      | out | out_valid/out_stall | sent frame, state, readings, counts
//  cfg_*      | in  | cfg_we              | register index and write data
//
// One word per cycle sustained while out_stall stays low: the step logic is a single
// pass from the input register into the context and output registers; a taken
// input word waits in the input register until its result word is loaded.
// in_stall rises only when the input register is full and a result waits on a
// stalled output.
// Synchronous active-low reset clears context and both valid flags and loads config defaults.
// Configuration is taken at any cycle with cfg_we high; no read-back.
module servo_can_poll_sequencer_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [7:0]         cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_cmd,
  input  logic               in_run,
  input  logic               in_enable_request,
  input  logic [7:0]         in_mode_request,
  input  logic signed [31:0] in_target_value,
  input  logic [10:0]        in_rx_id,
  input  logic [3:0]         in_rx_len,
  input  logic [63:0]        in_rx_bytes,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_tx_valid,
  output logic [10:0]        out_tx_id,
  output logic [2:0]         out_tx_len,
  output logic [47:0]        out_tx_bytes,
  output logic [3:0]         out_seq_state,
  output logic signed [31:0] out_speed_val,
  output logic signed [31:0] out_angle_val,
  output logic signed [31:0] out_current_val,
  output logic signed [31:0] out_torque_val,
  output logic [63:0]        out_read_error_counts
);

  scps_pkg::cfg_t  cfg_r;
  scps_pkg::ctx_t  ctx_r;
  scps_pkg::ctx_t  ctx_nxt;
  scps_pkg::item_t item_r;
  scps_pkg::tx_t   tx_nxt;
  scps_pkg::tx_t   tx_r;
  logic            in_valid_r;
  logic            out_valid_r;
  logic            in_acc;
  logic            adv;

  // the context only moves when a result is loaded, so it always matches
  // the word in the output register
  assign adv      = in_valid_r && !(out_valid_r && out_stall);
  assign in_stall = in_valid_r && !adv;
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.node_id          <= 7'd10;
      cfg_r.accept_setpoints <= 1'b1;
      cfg_r.torque_mode_code <= 8'd1;
      cfg_r.speed_mode_code  <= 8'd2;
    end else if (cfg_we) begin
      case (cfg_index)
        scps_pkg::CFG_NODE_ID:       cfg_r.node_id          <= cfg_wdata[6:0];
        scps_pkg::CFG_ACCEPT_SETPTS: cfg_r.accept_setpoints <= cfg_wdata[0];
        scps_pkg::CFG_TORQUE_MODE:   cfg_r.torque_mode_code <= cfg_wdata;
        scps_pkg::CFG_SPEED_MODE:    cfg_r.speed_mode_code  <= cfg_wdata;
        // none and position codes only name modes that send no target
        scps_pkg::CFG_NONE_MODE, scps_pkg::CFG_POSITION_MODE: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r.cmd            <= in_cmd;
      item_r.run            <= in_run;
      item_r.enable_request <= in_enable_request;
      item_r.mode_request   <= in_mode_request;
      item_r.target_value   <= in_target_value;
      item_r.rx_id          <= in_rx_id;
      item_r.rx_len         <= in_rx_len;
      item_r.rx_bytes       <= in_rx_bytes;
    end
    if (adv) tx_r <= tx_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      ctx_r       <= '{seq: scps_pkg::ST_OFF, held_mode: scps_pkg::NONE_MODE_RESET,
                       default: '0};
    end else begin
      if (in_acc) begin
        in_valid_r <= 1'b1;
      end else if (adv) begin
        in_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
        ctx_r       <= ctx_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  scps_step u_step (
    .ctx_cur (ctx_r),
    .item    (item_r),
    .cfg     (cfg_r),
    .ctx_nxt (ctx_nxt),
    .tx      (tx_nxt)
  );

  assign out_valid             = out_valid_r;
  assign out_tx_valid          = tx_r.valid;
  assign out_tx_id             = tx_r.id;
  assign out_tx_len            = tx_r.len;
  assign out_tx_bytes          = tx_r.bytes;
  assign out_seq_state         = ctx_r.seq;
  assign out_speed_val         = $signed(ctx_r.readings[0]);
  assign out_angle_val         = $signed(ctx_r.readings[1]);
  assign out_current_val       = $signed(ctx_r.readings[2]);
  assign out_torque_val        = $signed(ctx_r.readings[3]);
  assign out_read_error_counts = ctx_r.fails;

endmodule

// File: hw/rtl/scps_step.sv
// One sequencer step: next context and command frame for one word.
module scps_step (
  input  scps_pkg::ctx_t  ctx_cur,
  input  scps_pkg::item_t item,
  input  scps_pkg::cfg_t  cfg,
  output scps_pkg::ctx_t  ctx_nxt,
  output scps_pkg::tx_t   tx
);

  logic [10:0] rx_match_id;
  logic [63:0] keep_mask;
  logic [1:0]  q;
  logic        reply_ok;
  logic [31:0] reply_val;
  logic [3:0]  ok_state;

  assign rx_match_id = scps_pkg::RX_BASE + {4'd0, cfg.node_id};

  // bytes at or above the length code are dropped; DLC 8..15 keeps all
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      keep_mask[i*8 +: 8] = (item.rx_len > 4'(i)) ? 8'hFF : 8'h00;
    end
  end

  assign q         = 2'((ctx_cur.seq - scps_pkg::ST_SPD_RSP) >> 1);
  assign reply_ok  = (ctx_cur.pending_len == 4'd5) &&
                     (ctx_cur.pending_bytes[39:32] == scps_pkg::ACK_BYTE);
  assign reply_val = {ctx_cur.pending_bytes[7:0], ctx_cur.pending_bytes[15:8],
                      ctx_cur.pending_bytes[23:16], ctx_cur.pending_bytes[31:24]};
  assign ok_state  = (ctx_cur.seq == scps_pkg::ST_TRQ_RSP) ? scps_pkg::ST_SEND_EN
                                                           : ctx_cur.seq + 4'd1;

  always_comb begin
    ctx_nxt = ctx_cur;
    tx      = '0;
    if (item.cmd) begin
      ctx_nxt.pending_bytes = '0;
      if (item.rx_id == rx_match_id) begin
        ctx_nxt.pending_len   = item.rx_len;
        ctx_nxt.pending_bytes = item.rx_bytes & keep_mask;
        ctx_nxt.frame_pending = 1'b1;
      end
    end else begin
      if (cfg.accept_setpoints) begin
        ctx_nxt.held_enable = item.enable_request;
        ctx_nxt.held_mode   = item.mode_request;
        ctx_nxt.held_target = item.target_value;
      end
      case (ctx_cur.seq)
        scps_pkg::ST_OFF: begin
          if (item.run) ctx_nxt.seq = scps_pkg::ST_SEND_EN;
        end
        scps_pkg::ST_SEND_EN: begin
          if (!item.run) begin
            ctx_nxt.held_enable = 1'b0;
            ctx_nxt.held_target = '0;
          end
          if (ctx_nxt.held_enable != ctx_cur.sent_enable) begin
            tx.valid  = 1'b1;
            tx.len    = 3'd6;
            tx.bytes  = {7'd0, ctx_nxt.held_enable, 24'd0, 8'h00, 8'h01};
            ctx_nxt.after_ack   = scps_pkg::ST_SEND_MODE;
            ctx_nxt.seq         = scps_pkg::ST_WAIT_ACK;
            ctx_nxt.sent_enable = ctx_nxt.held_enable;
          end else begin
            ctx_nxt.seq = scps_pkg::ST_SEND_MODE;
          end
        end
        scps_pkg::ST_SEND_MODE: begin
          if (ctx_nxt.held_mode != ctx_cur.sent_mode) begin
            tx.valid  = 1'b1;
            tx.len    = 3'd6;
            tx.bytes  = {ctx_nxt.held_mode, 24'd0, 8'h4E, 8'h00};
            ctx_nxt.after_ack = scps_pkg::ST_SEND_TGT;
            ctx_nxt.seq       = scps_pkg::ST_WAIT_ACK;
            ctx_nxt.sent_mode = ctx_nxt.held_mode;
          end else begin
            ctx_nxt.seq = scps_pkg::ST_SEND_TGT;
          end
        end
        scps_pkg::ST_SEND_TGT: begin
          // any other mode parks here without sending
          if (ctx_nxt.held_mode == cfg.torque_mode_code ||
              ctx_nxt.held_mode == cfg.speed_mode_code) begin
            tx.valid  = 1'b1;
            tx.len    = 3'd6;
            tx.bytes  = {ctx_nxt.held_target[7:0], ctx_nxt.held_target[15:8],
                         ctx_nxt.held_target[23:16], ctx_nxt.held_target[31:24],
                         8'hFE, 8'h01};
            ctx_nxt.after_ack = scps_pkg::ST_SPD_REQ;
            ctx_nxt.seq       = scps_pkg::ST_WAIT_ACK;
          end
        end
        scps_pkg::ST_WAIT_ACK: begin
          if (ctx_cur.frame_pending) begin
            ctx_nxt.frame_pending = 1'b0;
            if (ctx_cur.pending_len == 4'd1 &&
                ctx_cur.pending_bytes[7:0] == scps_pkg::ACK_BYTE) begin
              ctx_nxt.seq = ctx_cur.after_ack;
            end else begin
              ctx_nxt.seq = scps_pkg::ST_ERROR;
            end
          end
        end
        scps_pkg::ST_SPD_REQ: begin
          tx.valid    = 1'b1;
          tx.len      = 3'd4;
          tx.bytes    = scps_pkg::REQ_SPEED;
          ctx_nxt.seq = scps_pkg::ST_SPD_RSP;
        end
        scps_pkg::ST_POS_REQ: begin
          tx.valid    = 1'b1;
          tx.len      = 3'd2;
          tx.bytes    = scps_pkg::REQ_POS;
          ctx_nxt.seq = scps_pkg::ST_POS_RSP;
        end
        scps_pkg::ST_CUR_REQ: begin
          tx.valid    = 1'b1;
          tx.len      = 3'd2;
          tx.bytes    = scps_pkg::REQ_CURRENT;
          ctx_nxt.seq = scps_pkg::ST_CUR_RSP;
        end
        scps_pkg::ST_TRQ_REQ: begin
          tx.valid    = 1'b1;
          tx.len      = 3'd2;
          tx.bytes    = scps_pkg::REQ_TORQUE;
          ctx_nxt.seq = scps_pkg::ST_TRQ_RSP;
        end
        scps_pkg::ST_SPD_RSP, scps_pkg::ST_POS_RSP,
        scps_pkg::ST_CUR_RSP, scps_pkg::ST_TRQ_RSP: begin
          if (ctx_cur.frame_pending) begin
            ctx_nxt.frame_pending = 1'b0;
            if (reply_ok) begin
              ctx_nxt.readings[q] = reply_val;
              ctx_nxt.seq         = ok_state;
            end else begin
              ctx_nxt.fails[q] = ctx_cur.fails[q] + 16'd1;
              ctx_nxt.seq      = ctx_cur.seq - 4'd1;
            end
          end
        end
        default: begin
          // error and unused codes hold
        end
      endcase
    end
    if (tx.valid) tx.id = scps_pkg::TX_BASE + {4'd0, cfg.node_id};
  end

endmodule

// File: hw/rtl/scps_checker.sv
// Port-level checks for the servo CAN poll sequencer, bound to the top level.
module scps_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_tx_valid,
  input logic [10:0] out_tx_id,
  input logic [2:0]  out_tx_len,
  input logic [47:0] out_tx_bytes,
  input logic [3:0]  out_seq_state
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_tx_bytes) &&
    $stable(out_seq_state))
    else $error("stalled result word changed");

  a_no_tx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_tx_valid |-> out_tx_id == 11'd0 && out_tx_len == 3'd0 &&
    out_tx_bytes == 48'd0)
    else $error("frame fields set without a frame");

  a_tx_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_tx_valid |-> out_tx_len == 3'd6 || out_tx_len == 3'd4 ||
    out_tx_len == 3'd2)
    else $error("bad frame length");

  a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_seq_state == scps_pkg::ST_ERROR |=>
    !out_valid || out_seq_state == scps_pkg::ST_ERROR)
    else $error("left the error state");

endmodule

bind servo_can_poll_sequencer_top scps_checker u_scps_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_tx_valid  (out_tx_valid),
  .out_tx_id     (out_tx_id),
  .out_tx_len    (out_tx_len),
  .out_tx_bytes  (out_tx_bytes),
  .out_seq_state (out_seq_state)
);

// File: tb/scps_checker.sv
// Result checker for the servo CAN poll sequencer: predicts each result word and compares it.
`timescale 1ns / 1ps

module scps_tb_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [7:0]         cfg_wdata,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               in_cmd,
  input  logic               in_run,
  input  logic               in_enable_request,
  input  logic [7:0]         in_mode_request,
  input  logic signed [31:0] in_target_value,
  input  logic [10:0]        in_rx_id,
  input  logic [3:0]         in_rx_len,
  input  logic [63:0]        in_rx_bytes,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               out_tx_valid,
  input  logic [10:0]        out_tx_id,
  input  logic [2:0]         out_tx_len,
  input  logic [47:0]        out_tx_bytes,
  input  logic [3:0]         out_seq_state,
  input  logic signed [31:0] out_speed_val,
  input  logic signed [31:0] out_angle_val,
  input  logic signed [31:0] out_current_val,
  input  logic signed [31:0] out_torque_val,
  input  logic [63:0]        out_read_error_counts,
  output int                 fail_count,
  output int                 waiting,
  output int                 results_seen,
  output logic [3:0]         seq_predicted
);

  // command frame header bytes
  localparam logic [7:0] OP_ENABLE_B0 = 8'h01;
  localparam logic [7:0] OP_ENABLE_B1 = 8'h00;
  localparam logic [7:0] OP_MODE_B0   = 8'h00;
  localparam logic [7:0] OP_MODE_B1   = 8'h4E;
  localparam logic [7:0] OP_TARGET_B0 = 8'h01;
  localparam logic [7:0] OP_TARGET_B1 = 8'hFE;

  localparam logic [2:0] CMD_LEN       = 3'd6;
  localparam logic [2:0] SPEED_REQ_LEN = 3'd4;
  localparam logic [2:0] POLL_REQ_LEN  = 3'd2;
  localparam logic [3:0] ACK_LEN       = 4'd1;
  localparam logic [3:0] REPLY_LEN     = 4'd5;

  localparam int Q_SPEED   = 0;
  localparam int Q_POS     = 1;
  localparam int Q_CURRENT = 2;
  localparam int Q_TORQUE  = 3;

  typedef struct packed {
    logic        tx_valid;
    logic [10:0] tx_id;
    logic [2:0]  tx_len;
    logic [47:0] tx_bytes;
    logic [3:0]  seq_state;
    logic [31:0] speed;
    logic [31:0] angle;
    logic [31:0] current;
    logic [31:0] torque;
    logic [63:0] err_counts;
  } status_t;

  // register copies
  logic [6:0]  node;
  logic        accept;
  logic [7:0]  trq_code;
  logic [7:0]  spd_code;

  // sequencer copy
  logic [3:0]  st;
  logic [3:0]  resume_st;
  logic        held_en;
  logic [7:0]  held_md;
  logic [31:0] held_tgt;
  logic        sent_en;
  logic [7:0]  sent_md;
  logic        rx_pend;
  logic [3:0]  rx_len_q;
  logic [63:0] rx_data_q;
  logic [31:0] reading [4];
  logic [15:0] fails [4];

  status_t         status_due [$];
  status_t         want;
  status_t         got;
  scps_pkg::item_t word_in;
  int              errors;

  function automatic logic [47:0] pack_cmd(logic [7:0] b0, logic [7:0] b1, logic [31:0] val);
    return {val[7:0], val[15:8], val[23:16], val[31:24], b1, b0};
  endfunction

  function automatic void take_reply(int q, logic [3:0] ok_st, logic [3:0] retry_st);
    if (rx_pend) begin
      rx_pend = 1'b0;
      if (rx_len_q == REPLY_LEN && rx_data_q[39:32] == scps_pkg::ACK_BYTE) begin
        reading[q] = {rx_data_q[7:0], rx_data_q[15:8], rx_data_q[23:16], rx_data_q[31:24]};
        st = ok_st;
      end else begin
        fails[q] = fails[q] + 16'd1;
        st = retry_st;
      end
    end
  endfunction

  function automatic void send_cmd(inout status_t r, input logic [47:0] data,
                                   input logic [3:0] next);
    r.tx_valid = 1'b1;
    r.tx_len   = CMD_LEN;
    r.tx_bytes = data;
    resume_st  = next;
    st         = scps_pkg::ST_WAIT_ACK;
  endfunction

  function automatic void send_poll(inout status_t r, input logic [2:0] len,
                                    input logic [47:0] data, input logic [3:0] next);
    r.tx_valid = 1'b1;
    r.tx_len   = len;
    r.tx_bytes = data;
    st         = next;
  endfunction

  function automatic status_t advance_sequencer(scps_pkg::item_t w);
    status_t     r;
    logic [63:0] keep;
    r = '0;
    if (w.cmd) begin
      // any frame wipes the held bytes, only ours is kept
      rx_data_q = '0;
      if (w.rx_id == scps_pkg::RX_BASE + {4'd0, node}) begin
        keep = w.rx_bytes;
        if (w.rx_len < 4'd8)
          keep &= (64'd1 << (w.rx_len * 8)) - 64'd1;
        rx_len_q  = w.rx_len;
        rx_data_q = keep;
        rx_pend   = 1'b1;
      end
    end else begin
      if (accept) begin
        held_en  = w.enable_request;
        held_md  = w.mode_request;
        held_tgt = w.target_value;
      end
      case (st)
        scps_pkg::ST_OFF: if (w.run) st = scps_pkg::ST_SEND_EN;
        scps_pkg::ST_SEND_EN: begin
          if (!w.run) begin
            held_en  = 1'b0;
            held_tgt = '0;
          end
          if (held_en != sent_en) begin
            send_cmd(r, pack_cmd(OP_ENABLE_B0, OP_ENABLE_B1, {31'd0, held_en}),
                     scps_pkg::ST_SEND_MODE);
            sent_en = held_en;
          end else begin
            st = scps_pkg::ST_SEND_MODE;
          end
        end
        scps_pkg::ST_SEND_MODE: begin
          if (held_md != sent_md) begin
            send_cmd(r, pack_cmd(OP_MODE_B0, OP_MODE_B1, {24'd0, held_md}),
                     scps_pkg::ST_SEND_TGT);
            sent_md = held_md;
          end else begin
            st = scps_pkg::ST_SEND_TGT;
          end
        end
        // other modes sit here without sending
        scps_pkg::ST_SEND_TGT: if (held_md == trq_code || held_md == spd_code)
          send_cmd(r, pack_cmd(OP_TARGET_B0, OP_TARGET_B1, held_tgt), scps_pkg::ST_SPD_REQ);
        scps_pkg::ST_WAIT_ACK: if (rx_pend) begin
          rx_pend = 1'b0;
          st = (rx_len_q == ACK_LEN && rx_data_q[7:0] == scps_pkg::ACK_BYTE) ? resume_st
                                                                           : scps_pkg::ST_ERROR;
        end
        scps_pkg::ST_SPD_REQ:
          send_poll(r, SPEED_REQ_LEN, scps_pkg::REQ_SPEED, scps_pkg::ST_SPD_RSP);
        scps_pkg::ST_SPD_RSP: take_reply(Q_SPEED, scps_pkg::ST_POS_REQ, scps_pkg::ST_SPD_REQ);
        scps_pkg::ST_POS_REQ:
          send_poll(r, POLL_REQ_LEN, scps_pkg::REQ_POS, scps_pkg::ST_POS_RSP);
        scps_pkg::ST_POS_RSP: take_reply(Q_POS, scps_pkg::ST_CUR_REQ, scps_pkg::ST_POS_REQ);
        scps_pkg::ST_CUR_REQ:
          send_poll(r, POLL_REQ_LEN, scps_pkg::REQ_CURRENT, scps_pkg::ST_CUR_RSP);
        scps_pkg::ST_CUR_RSP:
          take_reply(Q_CURRENT, scps_pkg::ST_TRQ_REQ, scps_pkg::ST_CUR_REQ);
        scps_pkg::ST_TRQ_REQ:
          send_poll(r, POLL_REQ_LEN, scps_pkg::REQ_TORQUE, scps_pkg::ST_TRQ_RSP);
        scps_pkg::ST_TRQ_RSP:
          take_reply(Q_TORQUE, scps_pkg::ST_SEND_EN, scps_pkg::ST_TRQ_REQ);
        default: ;
      endcase
    end
    if (r.tx_valid)
      r.tx_id = scps_pkg::TX_BASE + {4'd0, node};
    r.seq_state  = st;
    r.speed      = reading[Q_SPEED];
    r.angle      = reading[Q_POS];
    r.current    = reading[Q_CURRENT];
    r.torque     = reading[Q_TORQUE];
    r.err_counts = {fails[Q_TORQUE], fails[Q_CURRENT], fails[Q_POS], fails[Q_SPEED]};
    return r;
  endfunction

  function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      if (errors <= 10)
        $display("%t mismatch on %s in result word %0d: expected %h, got %h",
                 $realtime, name, results_seen, exp_v, act_v);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      node      = 7'd10;
      accept    = 1'b1;
      trq_code  = 8'd1;
      spd_code  = 8'd2;
      st        = scps_pkg::ST_OFF;
      resume_st = scps_pkg::ST_OFF;
      held_en   = 1'b0;
      held_md   = scps_pkg::NONE_MODE_RESET;
      held_tgt  = '0;
      sent_en   = 1'b0;
      sent_md   = '0;
      rx_pend   = 1'b0;
      rx_len_q  = '0;
      rx_data_q = '0;
      errors    = 0;
      for (int i = 0; i < 4; i++) begin
        reading[i] = '0;
        fails[i]   = '0;
      end
      status_due.delete();
      results_seen <= 0;
    end else begin
      if (cfg_we) begin
        // none and position codes are not kept
        case (cfg_index)
          scps_pkg::CFG_NODE_ID:       node     = cfg_wdata[6:0];
          scps_pkg::CFG_ACCEPT_SETPTS: accept   = cfg_wdata[0];
          scps_pkg::CFG_TORQUE_MODE:   trq_code = cfg_wdata;
          scps_pkg::CFG_SPEED_MODE:    spd_code = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        word_in.cmd            = in_cmd;
        word_in.run            = in_run;
        word_in.enable_request = in_enable_request;
        word_in.mode_request   = in_mode_request;
        word_in.target_value   = in_target_value;
        word_in.rx_id          = in_rx_id;
        word_in.rx_len         = in_rx_len;
        word_in.rx_bytes       = in_rx_bytes;
        status_due.push_back(advance_sequencer(word_in));
      end
      if (out_valid && !out_stall) begin
        got.tx_valid   = out_tx_valid;
        got.tx_id      = out_tx_id;
        got.tx_len     = out_tx_len;
        got.tx_bytes   = out_tx_bytes;
        got.seq_state  = out_seq_state;
        got.speed      = out_speed_val;
        got.angle      = out_angle_val;
        got.current    = out_current_val;
        got.torque     = out_torque_val;
        got.err_counts = out_read_error_counts;
        if (status_due.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%t result word with none outstanding: state %0d tx %b",
                     $realtime, got.seq_state, got.tx_valid);
        end else begin
          want = status_due.pop_front();
          check_field("tx_valid", want.tx_valid, got.tx_valid);
          check_field("tx_id", want.tx_id, got.tx_id);
          check_field("tx_len", want.tx_len, got.tx_len);
          check_field("tx_bytes", want.tx_bytes, got.tx_bytes);
          check_field("seq_state", want.seq_state, got.seq_state);
          check_field("speed reading", want.speed, got.speed);
          check_field("angle reading", want.angle, got.angle);
          check_field("current reading", want.current, got.current);
          check_field("torque reading", want.torque, got.torque);
          check_field("read_error_counts", want.err_counts, got.err_counts);
        end
        results_seen <= results_seen + 1;
      end
    end
    waiting       <= status_due.size();
    seq_predicted <= st;
    fail_count    <= errors;
  end

endmodule

// File: tb/tb_top.sv
// Testbench top for the servo CAN poll sequencer: stimulus, register settings and verdict.
`timescale 1ns / 1ps

module tb_top;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [7:0]         cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_cmd = 1'b0;
  logic               in_run = 1'b0;
  logic               in_enable_request = 1'b0;
  logic [7:0]         in_mode_request = '0;
  logic signed [31:0] in_target_value = '0;
  logic [10:0]        in_rx_id = '0;
  logic [3:0]         in_rx_len = '0;
  logic [63:0]        in_rx_bytes = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_tx_valid;
  logic [10:0]        out_tx_id;
  logic [2:0]         out_tx_len;
  logic [47:0]        out_tx_bytes;
  logic [3:0]         out_seq_state;
  logic signed [31:0] out_speed_val;
  logic signed [31:0] out_angle_val;
  logic signed [31:0] out_current_val;
  logic signed [31:0] out_torque_val;
  logic [63:0]        out_read_error_counts;

  int         fail_count;
  int         waiting;
  int         results_seen;
  logic [3:0] seq_predicted;

  int         sent_words = 0;
  bit         quiet = 1'b0;
  bit         reply_queued = 1'b0;
  logic [6:0] cur_node = 7'd10;
  logic [7:0] cur_none = 8'd0;
  logic [7:0] cur_trq = 8'd1;
  logic [7:0] cur_spd = 8'd2;
  logic [7:0] cur_pos = 8'd3;

  servo_can_poll_sequencer_top dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_cmd                (in_cmd),
    .in_run                (in_run),
    .in_enable_request     (in_enable_request),
    .in_mode_request       (in_mode_request),
    .in_target_value       (in_target_value),
    .in_rx_id              (in_rx_id),
    .in_rx_len             (in_rx_len),
    .in_rx_bytes           (in_rx_bytes),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_tx_valid          (out_tx_valid),
    .out_tx_id             (out_tx_id),
    .out_tx_len            (out_tx_len),
    .out_tx_bytes          (out_tx_bytes),
    .out_seq_state         (out_seq_state),
    .out_speed_val         (out_speed_val),
    .out_angle_val         (out_angle_val),
    .out_current_val       (out_current_val),
    .out_torque_val        (out_torque_val),
    .out_read_error_counts (out_read_error_counts)
  );

  scps_tb_checker u_checker (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_cmd                (in_cmd),
    .in_run                (in_run),
    .in_enable_request     (in_enable_request),
    .in_mode_request       (in_mode_request),
    .in_target_value       (in_target_value),
    .in_rx_id              (in_rx_id),
    .in_rx_len             (in_rx_len),
    .in_rx_bytes           (in_rx_bytes),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_tx_valid          (out_tx_valid),
    .out_tx_id             (out_tx_id),
    .out_tx_len            (out_tx_len),
    .out_tx_bytes          (out_tx_bytes),
    .out_seq_state         (out_seq_state),
    .out_speed_val         (out_speed_val),
    .out_angle_val         (out_angle_val),
    .out_current_val       (out_current_val),
    .out_torque_val        (out_torque_val),
    .out_read_error_counts (out_read_error_counts),
    .fail_count            (fail_count),
    .waiting               (waiting),
    .results_seen          (results_seen),
    .seq_predicted         (seq_predicted)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk)
    out_stall <= rst_n && !quiet && ($urandom_range(99) < 31);

  function automatic logic [10:0] match_id();
    return scps_pkg::RX_BASE + {4'd0, cur_node};
  endfunction

  function automatic logic [10:0] stray_id();
    logic [10:0] id;
    id = 11'($urandom_range(2047));
    if (id == match_id())
      id = id ^ 11'h1;
    return id;
  endfunction

  function automatic logic [7:0] pick_mode();
    int r;
    r = $urandom_range(99);
    if (r < 35) return cur_trq;
    if (r < 70) return cur_spd;
    if (r < 80) return cur_pos;
    if (r < 88) return cur_none;
    return 8'($urandom_range(255));
  endfunction

  // called at a falling edge, returns at the falling edge after the word is taken
  task automatic send_word(scps_pkg::item_t w);
    while (!quiet && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid          <= 1'b1;
    in_cmd            <= w.cmd;
    in_run            <= w.run;
    in_enable_request <= w.enable_request;
    in_mode_request   <= w.mode_request;
    in_target_value   <= w.target_value;
    in_rx_id          <= w.rx_id;
    in_rx_len         <= w.rx_len;
    in_rx_bytes       <= w.rx_bytes;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_words++;
    @(negedge clk);
  endtask

  task automatic send_tick(logic run, logic en, logic [7:0] md, logic [31:0] tgt);
    scps_pkg::item_t w;
    w = 122'({$urandom, $urandom, $urandom, $urandom});
    w.cmd            = 1'b0;
    w.run            = run;
    w.enable_request = en;
    w.mode_request   = md;
    w.target_value   = tgt;
    send_word(w);
    reply_queued = 1'b0;
  endtask

  task automatic send_frame(logic [10:0] id, logic [3:0] len, logic [63:0] data);
    scps_pkg::item_t w;
    w = 122'({$urandom, $urandom, $urandom, $urandom});
    w.cmd      = 1'b1;
    w.rx_id    = id;
    w.rx_len   = len;
    w.rx_bytes = data;
    send_word(w);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (waiting != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
  endtask

  task automatic set_regs(logic [6:0] node, logic acc, logic [7:0] none_c, logic [7:0] trq,
                          logic [7:0] spd, logic [7:0] pos);
    write_reg(scps_pkg::CFG_NODE_ID, {1'b0, node});
    write_reg(scps_pkg::CFG_ACCEPT_SETPTS, {7'd0, acc});
    write_reg(scps_pkg::CFG_NONE_MODE, none_c);
    write_reg(scps_pkg::CFG_TORQUE_MODE, trq);
    write_reg(scps_pkg::CFG_SPEED_MODE, spd);
    write_reg(scps_pkg::CFG_POSITION_MODE, pos);
    cfg_we   <= 1'b0;
    cur_node = node;
    cur_none = none_c;
    cur_trq  = trq;
    cur_spd  = spd;
    cur_pos  = pos;
  endtask

  // mostly the tick or reply the sequencer is waiting for, with stray and broken frames mixed in
  task automatic random_step();
    logic [63:0] data;
    logic [3:0]  len;
    data = {$urandom, $urandom};
    len  = 4'($urandom_range(15));
    if (!reply_queued && $urandom_range(99) < 8) begin
      send_frame(stray_id(), len, data);
    end else begin
      case (seq_predicted)
        scps_pkg::ST_OFF:
          send_tick($urandom_range(99) < 85, 1'($urandom_range(1)),
                    8'($urandom_range(255)), $urandom);
        scps_pkg::ST_SEND_EN, scps_pkg::ST_SEND_MODE, scps_pkg::ST_SEND_TGT:
          send_tick($urandom_range(99) < 92, 1'($urandom_range(1)), pick_mode(), $urandom);
        scps_pkg::ST_WAIT_ACK: begin
          if (!reply_queued) begin
            data[7:0] = scps_pkg::ACK_BYTE;
            send_frame(match_id(), 4'd1, data);
            reply_queued = 1'b1;
          end else begin
            send_tick(1'($urandom_range(1)), 1'($urandom_range(1)), pick_mode(), $urandom);
          end
        end
        scps_pkg::ST_SPD_RSP, scps_pkg::ST_POS_RSP, scps_pkg::ST_CUR_RSP,
        scps_pkg::ST_TRQ_RSP: begin
          if (!reply_queued) begin
            if ($urandom_range(99) < 75) begin
              data[39:32] = scps_pkg::ACK_BYTE;
              len = 4'd5;
            end else if ($urandom_range(1) != 0) begin
              data[39:32] = scps_pkg::ACK_BYTE ^ 8'($urandom_range(1, 255));
              len = 4'd5;
            end
            send_frame(match_id(), len, data);
            reply_queued = 1'b1;
          end else if ($urandom_range(99) < 10) begin
            // wipes the held bytes of the pending reply
            send_frame(stray_id(), len, data);
          end else begin
            send_tick(1'($urandom_range(1)), 1'($urandom_range(1)), pick_mode(), $urandom);
          end
        end
        scps_pkg::ST_SPD_REQ, scps_pkg::ST_POS_REQ, scps_pkg::ST_CUR_REQ,
        scps_pkg::ST_TRQ_REQ:
          send_tick(1'($urandom_range(1)), 1'($urandom_range(1)), pick_mode(), $urandom);
        default: begin
          if ($urandom_range(1) != 0)
            send_tick(1'($urandom_range(1)), 1'($urandom_range(1)),
                      8'($urandom_range(255)), $urandom);
          else
            send_frame(11'($urandom_range(2047)), len, data);
        end
      endcase
    end
  endtask

  initial begin
    int guard;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    // walk the enable, mode and target commands and the speed and position polls by hand
    send_tick(1'b0, 1'b1, cur_trq, 32'd0);
    send_tick(1'b1, 1'b1, cur_trq, 32'h7FFF_FFFF);
    send_tick(1'b1, 1'b1, cur_trq, 32'h7FFF_FFFF);
    send_frame(11'h7FF, 4'd8, '1);
    send_frame(match_id(), 4'd1, 64'hFFFF_FFFF_FFFF_FF3E);
    send_tick(1'b1, 1'b1, cur_trq, 32'h8000_0000);
    send_tick(1'b1, 1'b1, cur_trq, 32'h8000_0000);
    send_frame(match_id(), 4'd1, {56'd0, scps_pkg::ACK_BYTE});
    send_tick(1'b1, 1'b1, cur_trq, 32'h8000_0000);
    send_tick(1'b1, 1'b1, cur_trq, 32'h8000_0000);
    send_frame(match_id(), 4'd1, {56'd0, scps_pkg::ACK_BYTE});
    send_tick(1'b1, 1'b1, cur_trq, 32'h8000_0000);
    send_tick(1'b1, 1'b1, cur_trq, 32'h8000_0000);
    send_frame(match_id(), 4'd5, 64'h0000_003E_8000_0001);
    send_tick(1'b1, 1'b1, cur_trq, 32'h8000_0000);
    send_tick(1'b1, 1'b1, cur_trq, 32'h8000_0000);
    send_frame(match_id(), 4'd15, '1);
    send_tick(1'b1, 1'b1, cur_trq, 32'h8000_0000);
    send_tick(1'b1, 1'b1, cur_trq, 32'h8000_0000);
    send_frame(match_id(), 4'd5, 64'h0000_003F_1234_5678);
    send_tick(1'b1, 1'b1, cur_trq, 32'h8000_0000);
    send_tick(1'b1, 1'b1, cur_trq, 32'h8000_0000);
    send_frame(match_id(), 4'd5, 64'hFFFF_FF3E_FFFF_FFFF);
    send_tick(1'b1, 1'b1, cur_trq, 32'h8000_0000);
    drain();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: set_regs(7'd127, 1'b1, 8'd0, 8'hFF, 8'h00, 8'h80);
        1: set_regs(7'd0, 1'b0, 8'd0, 8'd1, 8'd2, 8'd3);
        2: set_regs(7'd55, 1'b1, 8'h33, 8'h5A, 8'h5A, 8'hA5);
        3: set_regs(7'd10, 1'b1, 8'd0, 8'd1, 8'd2, 8'd3);
        4: set_regs(7'($urandom_range(127)), 1'b1, 8'($urandom_range(255)),
                    8'($urandom_range(255)), 8'($urandom_range(255)),
                    8'($urandom_range(255)));
        default: set_regs(7'd1, 1'b1, 8'hFF, 8'h00, 8'hFF, 8'h00);
      endcase
      quiet = (p == 2);
      repeat (115) random_step();
      drain();
    end
    quiet = 1'b0;

    // finish with a wrong acknowledge, which latches the error for good
    set_regs(7'd10, 1'b1, 8'd0, 8'd1, 8'd2, 8'd3);
    guard = 0;
    while (!(seq_predicted == scps_pkg::ST_WAIT_ACK && !reply_queued) && guard < 400) begin
      random_step();
      guard++;
    end
    send_frame(match_id(), 4'd1, 64'h3F);
    send_tick(1'b1, 1'b1, cur_trq, $urandom);
    repeat (12) random_step();
    drain();
    repeat (6) @(negedge clk);

    $display("Summary: %0d words driven (ticks, replies, stray frames), %0d result words checked",
             sent_words, results_seen);
    $display("Summary: seven register settings, final predicted state %0d", seq_predicted);
    if (fail_count == 0 && waiting == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/scps_pkg.sv
hw/rtl/scps_step.sv
hw/rtl/servo_can_poll_sequencer_top.sv
hw/rtl/scps_checker.sv
tb/scps_checker.sv
tb/tb_top.sv
